/* rtl/core/oas_pkg.sv */
package oas_pkg;

	localparam int MAX_SIZE_DEF  = 16;
	localparam int COST_BITS_DEF = 24;
	localparam int SIZE_W        = 5;
	localparam int FIELD_W       = 4;
	localparam int DATA_W        = 32;
	localparam int ADDR_W        = 3;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
	localparam logic              REG_MATRIX_SIZE = 1'b0;

	typedef struct packed {
		logic idle;
		logic solve_init;
		logic pass_init;
		logic phase_start;
		logic scan;
		logic update;
		logic aug_link;
		logic aug_move;
		logic build;
		logic emit;
	} oas_cmd_t;

	typedef struct packed {
		logic go;
		logic j_last;
		logic owner_zero;
		logic prev_zero;
		logic rows_done;
		logic emit_done;
	} oas_sts_t;

endpackage

/* rtl/core/optimal_assignment_solver.sv */
// Channel  | Signals                                                         | Direction
// input    | in_valid, in_stall, cost, last_entry                            | into block
// output   | out_valid, out_stall, row_index, assigned_column, last_result   | out of block
// config   | psel, penable, pwrite, paddr, pwdata, prdata, pready            | APB register port
//
// The transaction flagged last starts a solve; each augmenting phase scans one column a cycle
// over the cost store's single read port, and each row pass adds a pass-init state and an
// aug-link and an aug-move state per path step.
// Reset clears the controller and counters; the cost store is not cleared.
// The input stalls from the last entry until the controller is back in idle after the last result is taken;
// an output stall holds the result register and pauses emission.
module optimal_assignment_solver import oas_pkg::*; #(
	parameter int MAX_SIZE  = MAX_SIZE_DEF,
	parameter int COST_BITS = COST_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COST_BITS-1:0] cost,
	input  logic                 last_entry,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [FIELD_W-1:0]   row_index,
	output logic [FIELD_W-1:0]   assigned_column,
	output logic                 last_result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	logic [SIZE_W-1:0] size_q;
	oas_cmd_t          cmd;
	oas_sts_t          sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_MATRIX_SIZE) begin
			size_q <= pwdata[SIZE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? DATA_W'(size_q) : '0;

	oas_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.sts   (sts),
		.cmd   (cmd)
	);

	oas_dpath #(.MAX_SIZE(MAX_SIZE), .COST_BITS(COST_BITS)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.size_cfg       (size_q),
		.in_valid       (in_valid),
		.cost           (cost),
		.last_entry     (last_entry),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.row_index      (row_index),
		.assigned_column(assigned_column),
		.last_result    (last_result)
	);

	assign in_stall = !cmd.idle;

endmodule

/* rtl/core/oas_ram.sv */
module oas_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/oas_ctrl.sv */
module oas_ctrl import oas_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  oas_sts_t sts,
	output oas_cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE        = 12'b000000000001,
		S_SOLVE_INIT  = 12'b000000000010,
		S_PASS_INIT   = 12'b000000000100,
		S_PHASE_START = 12'b000000001000,
		S_SCAN        = 12'b000000010000,
		S_DRAIN       = 12'b000000100000,
		S_UPDATE      = 12'b000001000000,
		S_CHECK       = 12'b000010000000,
		S_AUG_LINK    = 12'b000100000000,
		S_AUG_MOVE    = 12'b001000000000,
		S_BUILD       = 12'b010000000000,
		S_EMIT        = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (sts.go) state_d = S_SOLVE_INIT;
			end
			S_SOLVE_INIT: begin
				cmd.solve_init = 1'b1;
				state_d = S_PASS_INIT;
			end
			S_PASS_INIT: begin
				cmd.pass_init = 1'b1;
				state_d = S_PHASE_START;
			end
			S_PHASE_START: begin
				cmd.phase_start = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.j_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = sts.owner_zero ? S_AUG_LINK : S_PHASE_START;
			end
			S_AUG_LINK: begin
				cmd.aug_link = 1'b1;
				state_d = S_AUG_MOVE;
			end
			S_AUG_MOVE: begin
				cmd.aug_move = 1'b1;
				if (sts.prev_zero) state_d = sts.rows_done ? S_BUILD : S_PASS_INIT;
				else state_d = S_AUG_LINK;
			end
			S_BUILD: begin
				cmd.build = 1'b1;
				if (sts.j_last) state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_done) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && sts.go) |=> state_q == S_SOLVE_INIT)
		else $error("solve did not start after the last entry");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && sts.j_last) |=> state_q == S_DRAIN)
		else $error("scan did not drain");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && sts.emit_done) |=> cmd.idle)
		else $error("emit did not return to idle");

endmodule

/* rtl/core/oas_dpath.sv */
module oas_dpath import oas_pkg::*; #(
	parameter int MAX_SIZE  = MAX_SIZE_DEF,
	parameter int COST_BITS = COST_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  oas_cmd_t             cmd,
	output oas_sts_t             sts,
	input  logic [SIZE_W-1:0]    size_cfg,
	input  logic                 in_valid,
	input  logic [COST_BITS-1:0] cost,
	input  logic                 last_entry,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [FIELD_W-1:0]   row_index,
	output logic [FIELD_W-1:0]   assigned_column,
	output logic                 last_result
);

	localparam int NC    = MAX_SIZE + 1;
	localparam int IW    = $clog2(MAX_SIZE + 1);
	localparam int CW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DW    = COST_BITS + 10;
	localparam logic signed [DW-1:0] INF = {1'b0, {(DW-1){1'b1}}};

	logic [CNT_W-1:0]     cnt_q;
	logic [IW-1:0]        nn_q, i_q, j_q, cur_q, prev_q, next_q, j_s1, oc_q, ix;
	logic                 v_s1, ov_q, sent_all_q;
	logic [AW-1:0]        base_q;
	logic signed [DW-1:0] ur_q, delta_q;
	logic signed [DW-1:0] ucol_q [NC];
	logic signed [DW-1:0] vcol_q [NC];
	logic signed [DW-1:0] slack_q [NC];
	logic [IW-1:0]        owner_q [NC];
	logic [IW-1:0]        link_q [NC];
	logic [NC-1:0]        used_q;
	logic [CW-1:0]        r2c_q [MAX_SIZE];
	logic [FIELD_W-1:0]   row_q, col_q;
	logic                 last_q;

	logic                 acc, we, load;
	logic [AW-1:0]        raddr;
	logic [COST_BITS-1:0] rdata;
	logic [IW-1:0]        eff, owner_rd, link_rd;
	logic signed [DW-1:0] ucol_rd, v_rd, slack_rd, s, ns;
	logic                 used_rd;

	always_comb begin
		if (size_cfg == '0) eff = IW'(1);
		else if (int'(size_cfg) > MAX_SIZE) eff = IW'(MAX_SIZE);
		else eff = IW'(size_cfg);
	end

	assign acc = in_valid && cmd.idle;
	assign we  = acc && (cnt_q < CNT_W'(DEPTH));
	assign raddr = AW'(base_q + AW'(j_q - IW'(1)));

	oas_ram #(.WIDTH(COST_BITS), .DEPTH(DEPTH), .AW(AW)) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(cost),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		priority if (v_s1) ix = j_s1;
		else if (cmd.aug_move) ix = prev_q;
		else if (cmd.build) ix = j_q;
		else ix = cur_q;
	end

	assign owner_rd = owner_q[ix];
	assign link_rd  = link_q[ix];
	assign ucol_rd  = ucol_q[ix];
	assign v_rd     = vcol_q[ix];
	assign slack_rd = slack_q[ix];
	assign used_rd  = used_q[ix];

	assign s  = $signed({{(DW-COST_BITS){1'b0}}, rdata}) - ur_q - v_rd;
	assign ns = (s < slack_rd) ? s : slack_rd;

	assign load = cmd.emit && !sent_all_q && (!ov_q || !out_stall);

	assign sts.go         = acc && last_entry;
	assign sts.j_last     = (j_q == nn_q);
	assign sts.owner_zero = (owner_rd == '0);
	assign sts.prev_zero  = (prev_q == '0);
	assign sts.rows_done  = (i_q == nn_q);
	assign sts.emit_done  = sent_all_q && !ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			v_s1       <= 1'b0;
			ov_q       <= 1'b0;
			sent_all_q <= 1'b0;
			oc_q       <= '0;
		end else begin
			if (acc) begin
				if (last_entry) cnt_q <= '0;
				else if (we) cnt_q <= cnt_q + CNT_W'(1);
			end
			v_s1 <= cmd.scan;
			if (cmd.solve_init) begin
				oc_q       <= '0;
				sent_all_q <= 1'b0;
			end else if (load) begin
				oc_q <= oc_q + IW'(1);
				if (oc_q == nn_q - IW'(1)) sent_all_q <= 1'b1;
			end
			if (load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.solve_init) begin
			nn_q <= eff;
			i_q  <= IW'(1);
			for (int k = 0; k < NC; k++) begin
				ucol_q[k]  <= '0;
				vcol_q[k]  <= '0;
				owner_q[k] <= '0;
				link_q[k]  <= '0;
			end
		end
		if (cmd.pass_init) begin
			owner_q[0] <= i_q;
			ucol_q[0]  <= '0;
			cur_q      <= '0;
			used_q     <= '0;
			for (int k = 0; k < NC; k++) slack_q[k] <= INF;
		end
		if (cmd.phase_start) begin
			used_q[cur_q] <= 1'b1;
			ur_q    <= ucol_rd;
			base_q  <= AW'(owner_rd - IW'(1)) * AW'(nn_q);
			delta_q <= INF;
			next_q  <= '0;
			j_q     <= IW'(1);
		end
		if (cmd.scan) begin
			j_s1 <= j_q;
			j_q  <= j_q + IW'(1);
		end
		if (v_s1 && !used_rd) begin
			if (s < slack_rd) begin
				slack_q[j_s1] <= s;
				link_q[j_s1]  <= cur_q;
			end
			if (ns < delta_q) begin
				delta_q <= ns;
				next_q  <= j_s1;
			end
		end
		if (cmd.update) begin
			cur_q <= next_q;
			for (int k = 0; k < NC; k++) begin
				if (used_q[k]) begin
					ucol_q[k] <= ucol_q[k] + delta_q;
					vcol_q[k] <= vcol_q[k] - delta_q;
				end else if (slack_q[k] != INF) begin
					slack_q[k] <= slack_q[k] - delta_q;
				end
			end
		end
		if (cmd.aug_link) begin
			prev_q <= link_rd;
		end
		if (cmd.aug_move) begin
			owner_q[cur_q] <= owner_rd;
			ucol_q[cur_q]  <= ucol_rd;
			cur_q          <= prev_q;
			j_q            <= IW'(1);
			if (prev_q == '0) i_q <= i_q + IW'(1);
		end
		if (cmd.build) begin
			r2c_q[CW'(owner_rd - IW'(1))] <= CW'(j_q - IW'(1));
			j_q <= j_q + IW'(1);
		end
		if (load) begin
			row_q  <= FIELD_W'(oc_q);
			col_q  <= FIELD_W'(r2c_q[CW'(oc_q)]);
			last_q <= (oc_q == nn_q - IW'(1));
		end
	end

	assign out_valid       = ov_q;
	assign row_index       = row_q;
	assign assigned_column = col_q;
	assign last_result     = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (j_s1 != '0 && j_s1 <= nn_q))
		else $error("scan column out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> next_q != '0)
		else $error("no unused column found in scan");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.aug_move |-> cur_q != '0)
		else $error("augmenting path writes the root column");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.build |-> (owner_rd != '0 && owner_rd <= nn_q))
		else $error("column left without an owner row");

endmodule

/* sim/optimal_assignment_solver_test.sv */
module optimal_assignment_solver_test;
	import oas_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_MAX = MAX_SIZE_DEF;
	localparam int DEPTH = N_MAX * N_MAX;
	localparam longint INF = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [23:0] CMAX = 24'hFFFFFF;
	localparam int LIMIT = 1000000;

	typedef struct {
		logic [3:0] row;
		logic [3:0] col;
		logic last;
	} assign_t;

	typedef struct {
		logic [4:0] size;
		logic [23:0] c;
		logic l;
		bit known;
		logic [63:0] cols;
	} step_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [23:0] cost = 0;
	logic last_entry = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [3:0] row_index;
	logic [3:0] assigned_column;
	logic last_result;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [ADDR_W-1:0] paddr = 0;
	logic [DATA_W-1:0] pwdata = 0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	optimal_assignment_solver uut (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	logic [23:0] cost_mem[DEPTH];
	bit written[DEPTH];
	int fill_count;
	logic [4:0] size_reg;
	longint row_pot[N_MAX+1], col_pot[N_MAX+1], slack[N_MAX+1];
	int owner[N_MAX+1], link[N_MAX+1];
	bit used[N_MAX+1];

	assign_t pending_assign[$];
	int errors = 0;
	int matrices = 0;
	int results_seen = 0;
	int items_sent = 0;
	int cycles = 0;
	int idle_in = 0;
	int stall_out = 0;
	bit forced = 0;
	assign_t forced_q[$];

	function automatic int eff_size(logic [4:0] s);
		if (s == 0) return 1;
		if (s > N_MAX) return N_MAX;
		return int'(s);
	endfunction

	function automatic void solve_assignment(int n);
		int cur, nxt, r;
		longint s, delta;
		for (int j = 0; j <= N_MAX; j++) begin
			row_pot[j] = 0;
			col_pot[j] = 0;
			owner[j] = 0;
			link[j] = 0;
		end
		for (int i = 1; i <= n; i++) begin
			cur = 0;
			owner[0] = i;
			for (int j = 0; j <= n; j++) begin
				slack[j] = INF;
				used[j] = 0;
			end
			do begin
				r = owner[cur];
				nxt = 0;
				delta = INF;
				used[cur] = 1;
				for (int j = 1; j <= n; j++) begin
					if (!used[j]) begin
						s = longint'(cost_mem[(r-1)*n + j-1]) - row_pot[r] - col_pot[j];
						if (s < slack[j]) begin
							slack[j] = s;
							link[j] = cur;
						end
						if (slack[j] < delta) begin
							delta = slack[j];
							nxt = j;
						end
					end
				end
				for (int j = 0; j <= n; j++) begin
					if (used[j]) begin
						row_pot[owner[j]] += delta;
						col_pot[j] -= delta;
					end else if (slack[j] != INF) begin
						slack[j] -= delta;
					end
				end
				cur = nxt;
			end while (nxt != 0 && owner[cur] != 0);
			do begin
				nxt = link[cur];
				owner[cur] = owner[nxt];
				cur = nxt;
			end while (cur != 0);
		end
	endfunction

	function automatic void accept_entry(logic [23:0] c, logic l);
		int n;
		int col_of[N_MAX];
		assign_t a;
		if (fill_count < DEPTH) begin
			cost_mem[fill_count] = c;
			written[fill_count] = 1;
			fill_count++;
		end
		if (!l) return;
		n = eff_size(size_reg);
		solve_assignment(n);
		fill_count = 0;
		matrices++;
		for (int r = 0; r < N_MAX; r++) col_of[r] = 0;
		for (int j = 1; j <= n; j++)
			if (owner[j] >= 1 && owner[j] <= n) col_of[owner[j]-1] = j - 1;
		for (int r = 0; r < n; r++) begin
			a.row = 4'(r);
			a.col = 4'(col_of[r]);
			a.last = (r == n - 1);
			if (forced) a = forced_q.pop_front();
			pending_assign = {pending_assign, a};
		end
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout with %0d assignments outstanding", pending_assign.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_out);

	always @(posedge clk) begin
		assign_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_assign.size() == 0) begin
				report_mismatch("unexpected transaction, row", row_index, 0);
			end else begin
				e = pending_assign.pop_front();
				if (row_index !== e.row) report_mismatch("row_index", row_index, e.row);
				if (assigned_column !== e.col)
					report_mismatch("assigned_column", assigned_column, e.col);
				if (last_result !== e.last) report_mismatch("last_result", last_result, e.last);
			end
		end
	end

	task automatic send_entry(logic [23:0] c, logic l);
		while ($urandom_range(99) < idle_in) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cost <= c;
		last_entry <= l;
		do @(posedge clk); while (in_stall);
		items_sent++;
		accept_entry(c, l);
	endtask

	task automatic settle;
		in_valid <= 0;
		wait (pending_assign.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_size(logic [4:0] s);
		settle();
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'(4 * int'(REG_MATRIX_SIZE));
		pwdata <= ($urandom & 32'hFFFF_FFE0) | 32'(s);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		size_reg = s;
		@(posedge clk);
	endtask

	function automatic logic [23:0] pick_cost(int mode);
		case (mode)
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 3));
			default: return $urandom_range(0, 1) ? CMAX : 24'd0;
		endcase
	endfunction

	task automatic send_matrix(int count);
		int mode;
		mode = $urandom_range(0, 2);
		for (int k = 0; k < count; k++) send_entry(pick_cost(mode), k == count - 1);
	endtask

	task automatic random_phase(int budget);
		int start, n, p, count;
		bit ok;
		start = items_sent;
		while (items_sent - start < budget) begin
			p = $urandom_range(99);
			if (p < 4) write_size(5'd0);
			else if (p < 25) write_size(5'($urandom_range(1, 6)));
			n = eff_size(size_reg);
			p = $urandom_range(99);
			count = n * n;
			if (p < 8 && n > 1) begin
				count = $urandom_range(1, n * n - 1);
				ok = 1;
				for (int a = count; a < n * n; a++) if (!written[a]) ok = 0;
				if (!ok) count = n * n;
			end else if (p < 15) begin
				count = n * n + $urandom_range(1, 3);
			end
			send_matrix(count);
		end
	endtask

	step_t steps[] = '{
		'{5'd1, CMAX, 1, 1, 64'h0},
		'{5'd2, 24'd0, 0, 0, 0}, '{5'd2, CMAX, 0, 0, 0},
		'{5'd2, CMAX, 0, 0, 0}, '{5'd2, 24'd0, 1, 1, 64'h10},
		'{5'd2, CMAX, 0, 0, 0}, '{5'd2, 24'd0, 0, 0, 0},
		'{5'd2, 24'd0, 0, 0, 0}, '{5'd2, CMAX, 1, 1, 64'h01},
		'{5'd2, 24'd5, 0, 0, 0}, '{5'd2, 24'd5, 0, 0, 0},
		'{5'd2, 24'd5, 0, 0, 0}, '{5'd2, 24'd5, 1, 0, 0},
		'{5'd2, 24'd7, 1, 0, 0},
		'{5'd0, 24'h800001, 1, 1, 64'h0},
		'{5'd3, 24'd3, 0, 0, 0}, '{5'd3, 24'd1, 0, 0, 0}, '{5'd3, 24'd2, 0, 0, 0},
		'{5'd3, 24'd2, 0, 0, 0}, '{5'd3, 24'd3, 0, 0, 0}, '{5'd3, 24'd1, 0, 0, 0},
		'{5'd3, 24'd1, 0, 0, 0}, '{5'd3, 24'd2, 0, 0, 0}, '{5'd3, 24'd3, 1, 0, 0}
	};

	initial begin
		assign_t a;
		int n;
		size_reg = SIZE_RESET;
		fill_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].size != size_reg) write_size(steps[i].size);
			forced = steps[i].known;
			if (forced) begin
				n = eff_size(steps[i].size);
				for (int r = 0; r < n; r++) begin
					a.row = 4'(r);
					a.col = steps[i].cols[4*r +: 4];
					a.last = (r == n - 1);
					forced_q = {forced_q, a};
				end
			end
			send_entry(steps[i].c, steps[i].l);
			forced = 0;
		end

		idle_in = 0; stall_out = 0;
		random_phase(60);
		settle();
		idle_in = 81; stall_out = 0;
		random_phase(55);
		settle();
		idle_in = 0; stall_out = 81;
		random_phase(55);
		settle();
		idle_in = 38; stall_out = 38;
		random_phase(55);
		settle();
		stall_out = 0;
		repeat (100) @(posedge clk);

		$display("Solved %0d cost matrices from %0d entries, checked %0d row assignments,",
			matrices, items_sent, results_seen);
		$display("with sizes 1 to 6, a zero size, short and overlong matrices.");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
